// ===== hw/rtl/u16u8_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// u16u8_pkg
// Shared types, constants and byte-encoding helpers for the UTF-16 to UTF-8
// transcoder: the job record passed from the front end to the back end.
// ----------------------------------------------------------------------------
package u16u8_pkg;

   // job queue geometry
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   // surrogate ranges
   localparam logic [15:0] SURR_HIGH_MIN = 16'hD800;
   localparam logic [15:0] SURR_HIGH_MAX = 16'hDBFF;
   localparam logic [15:0] SURR_LOW_MIN  = 16'hDC00;
   localparam logic [15:0] SURR_LOW_MAX  = 16'hDFFF;

   // code point limits of the utf-8 length classes
   localparam logic [20:0] CP_LIMIT_1   = 21'h00080;
   localparam logic [20:0] CP_LIMIT_2   = 21'h00800;
   localparam logic [20:0] CP_LIMIT_3   = 21'h10000;
   localparam logic [20:0] CP_SUPP_BASE = 21'h10000;

   // high surrogate prefix used when a held unit is flushed alone
   localparam logic [5:0] SURR_HIGH_PREFIX = 6'b110110;

   // what a job does after an optional flushed surrogate
   typedef enum logic [1:0] {
      MAIN_NONE,
      MAIN_POINT,
      MAIN_PATH_END,
      MAIN_LIST_END
   } main_kind_type;

   // one queued job: everything a single input item causes
   typedef struct packed {
      logic          flush_vld;
      logic [9:0]    flush_pay;
      main_kind_type main_kind;
      logic [20:0]   main_cp;
      logic [2:0]    main_len;
   } job_type;

   // number of utf-8 bytes for a code point
   function automatic logic [2:0] utf8_len(input logic [20:0] cp);
      logic [2:0] len;
      if (cp < CP_LIMIT_1) begin
         len = 3'd1;
      end else if (cp < CP_LIMIT_2) begin
         len = 3'd2;
      end else if (cp < CP_LIMIT_3) begin
         len = 3'd3;
      end else begin
         len = 3'd4;
      end
      return len;
   endfunction

   // byte number idx of the utf-8 sequence of length len for cp
   function automatic logic [7:0] utf8_byte(input logic [20:0] cp,
                                            input logic [2:0]  len,
                                            input logic [1:0]  idx);
      logic [7:0] b;
      b = 8'h00;
      case (len)
         3'd1: b = {1'b0, cp[6:0]};
         3'd2: begin
            case (idx)
               2'd0:    b = {3'b110, cp[10:6]};
               default: b = {2'b10, cp[5:0]};
            endcase
         end
         3'd3: begin
            case (idx)
               2'd0:    b = {4'b1110, cp[15:12]};
               2'd1:    b = {2'b10, cp[11:6]};
               default: b = {2'b10, cp[5:0]};
            endcase
         end
         default: begin
            case (idx)
               2'd0:    b = {5'b11110, cp[20:18]};
               2'd1:    b = {2'b10, cp[17:12]};
               2'd2:    b = {2'b10, cp[11:6]};
               default: b = {2'b10, cp[5:0]};
            endcase
         end
      endcase
      return b;
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/u16u8_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// u16u8_front
// Accepts code units, tracks the held high surrogate and the path-start flag,
// and turns each item into one job for the back end; a high surrogate that is only held gives no job.
// ----------------------------------------------------------------------------
module u16u8_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               accept,
   input  wire logic [15:0]        code_unit,
   output      logic               push,
   output      u16u8_pkg::job_type job
);

   logic       held_vld_ff, held_vld_in;
   logic [9:0] held_pay_ff, held_pay_in;
   logic       path_empty_ff, path_empty_in;
   logic       is_high, is_low, produce;

   // classify the unit and build the job
   always_comb begin
      is_high = code_unit inside {[u16u8_pkg::SURR_HIGH_MIN:u16u8_pkg::SURR_HIGH_MAX]};
      is_low  = code_unit inside {[u16u8_pkg::SURR_LOW_MIN:u16u8_pkg::SURR_LOW_MAX]};

      job           = '0;
      job.main_kind = u16u8_pkg::MAIN_NONE;
      held_vld_in   = held_vld_ff;
      held_pay_in   = held_pay_ff;
      path_empty_in = path_empty_ff;

      if (held_vld_ff && is_low) begin
         // pair completes a supplementary code point
         job.main_kind = u16u8_pkg::MAIN_POINT;
         job.main_cp   = {1'b0, held_pay_ff, code_unit[9:0]} + u16u8_pkg::CP_SUPP_BASE;
         job.main_len  = 3'd4;
         held_vld_in   = 1'b0;
         held_pay_in   = '0;
      end else begin
         // a held surrogate that cannot pair goes out first
         job.flush_vld = held_vld_ff;
         job.flush_pay = held_pay_ff;
         held_vld_in   = 1'b0;
         held_pay_in   = '0;
         if (code_unit == 16'h0000) begin
            job.main_kind = path_empty_ff ? u16u8_pkg::MAIN_LIST_END
                                          : u16u8_pkg::MAIN_PATH_END;
            job.main_len  = 3'd1;
            path_empty_in = 1'b1;
         end else if (is_high) begin
            held_vld_in   = 1'b1;
            held_pay_in   = code_unit[9:0];
            path_empty_in = 1'b0;
         end else begin
            job.main_kind = u16u8_pkg::MAIN_POINT;
            job.main_cp   = {5'd0, code_unit};
            job.main_len  = u16u8_pkg::utf8_len({5'd0, code_unit});
            path_empty_in = 1'b0;
         end
      end

      produce = job.flush_vld || (job.main_kind != u16u8_pkg::MAIN_NONE);
      push    = accept && produce;
   end

   // surrogate and path state
   always_ff @(posedge clock) begin
      if (reset) begin
         held_vld_ff   <= 1'b0;
         held_pay_ff   <= '0;
         path_empty_ff <= 1'b1;
      end else if (accept) begin
         held_vld_ff   <= held_vld_in;
         held_pay_ff   <= held_pay_in;
         path_empty_ff <= path_empty_in;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/u16u8_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// u16u8_queue
// Small job fifo between front and back end, with a direct head view.
// ----------------------------------------------------------------------------
module u16u8_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire u16u8_pkg::job_type push_job,
   input  wire logic               pop,
   output      logic               full,
   output      logic               head_vld,
   output      u16u8_pkg::job_type head_job
);

   u16u8_pkg::job_type              slot_ff [u16u8_pkg::QUEUE_DEPTH];
   logic [u16u8_pkg::QUEUE_AW-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [u16u8_pkg::QUEUE_CW-1:0]  count_ff;

   // status and head
   always_comb begin
      full     = (count_ff == u16u8_pkg::QUEUE_CW'(u16u8_pkg::QUEUE_DEPTH));
      head_vld = (count_ff != '0);
      head_job = slot_ff[rd_ptr_ff];
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   // no overflow, no underflow, count tracks pushes
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full && !pop))
      else $error("job queue push while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_vld)
      else $error("job queue pop while empty");

   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("job queue count did not follow push");

endmodule
`default_nettype wire

// ===== hw/rtl/u16u8_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// u16u8_back
// Byte sequencer: walks the current job one utf-8 byte or marker per cycle,
// while rsp_stall does not hold the result register, into that register.
// ----------------------------------------------------------------------------
module u16u8_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               head_vld,
   input  wire u16u8_pkg::job_type head_job,
   output      logic               pop,
   output      logic               rsp_valid,
   input  wire logic               rsp_stall,
   output      logic [7:0]         rsp_out_byte,
   output      logic               rsp_byte_valid,
   output      logic               rsp_path_end,
   output      logic               rsp_list_end,
   output      logic               rsp_last
);

   u16u8_pkg::job_type cur_ff;
   logic               cur_vld_ff;
   logic               main_phase_ff;
   logic [1:0]         idx_ff;

   logic               out_vld_ff;
   logic [7:0]         out_byte_ff;
   logic               out_bv_ff, out_pe_ff, out_le_ff, out_last_ff;

   logic               out_ready, advance, seg_done, is_last, load;
   logic [7:0]         byte_in;
   logic               bv_in, pe_in, le_in;

   // current byte of the job
   always_comb begin
      byte_in  = 8'h00;
      bv_in    = 1'b0;
      pe_in    = 1'b0;
      le_in    = 1'b0;
      seg_done = 1'b1;
      is_last  = 1'b1;
      if (!main_phase_ff) begin
         byte_in  = u16u8_pkg::utf8_byte({5'd0, u16u8_pkg::SURR_HIGH_PREFIX, cur_ff.flush_pay},
                                         3'd3, idx_ff);
         bv_in    = 1'b1;
         seg_done = (idx_ff == 2'd2);
         is_last  = seg_done && (cur_ff.main_kind == u16u8_pkg::MAIN_NONE);
      end else begin
         case (cur_ff.main_kind)
            u16u8_pkg::MAIN_POINT: begin
               byte_in  = u16u8_pkg::utf8_byte(cur_ff.main_cp, cur_ff.main_len, idx_ff);
               bv_in    = 1'b1;
               seg_done = ({1'b0, idx_ff} == (cur_ff.main_len - 3'd1));
            end
            u16u8_pkg::MAIN_PATH_END: pe_in = 1'b1;
            u16u8_pkg::MAIN_LIST_END: le_in = 1'b1;
            default: ;
         endcase
         is_last = seg_done;
      end

      out_ready = !out_vld_ff || !rsp_stall;
      advance   = cur_vld_ff && out_ready;
      load      = !cur_vld_ff || (advance && is_last);
      pop       = load && head_vld;
   end

   // job sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_vld_ff    <= 1'b0;
         main_phase_ff <= 1'b0;
         idx_ff        <= '0;
      end else if (load) begin
         cur_vld_ff    <= head_vld;
         main_phase_ff <= !head_job.flush_vld;
         idx_ff        <= '0;
      end else if (advance) begin
         if (seg_done) begin
            main_phase_ff <= 1'b1;
            idx_ff        <= '0;
         end else begin
            idx_ff <= idx_ff + 1'b1;
         end
      end
   end

   // job payload
   always_ff @(posedge clock) begin
      if (load) begin
         cur_ff <= head_job;
      end
   end

   // result register, control
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (out_ready) begin
         out_vld_ff <= advance;
      end
   end

   // result register, payload
   always_ff @(posedge clock) begin
      if (advance) begin
         out_byte_ff <= byte_in;
         out_bv_ff   <= bv_in;
         out_pe_ff   <= pe_in;
         out_le_ff   <= le_in;
         out_last_ff <= is_last;
      end
   end

   assign rsp_valid      = out_vld_ff;
   assign rsp_out_byte   = out_byte_ff;
   assign rsp_byte_valid = out_bv_ff;
   assign rsp_path_end   = out_pe_ff;
   assign rsp_list_end   = out_le_ff;
   assign rsp_last       = out_last_ff;

   // flush phase only for jobs that carry a flushed surrogate
   a_flush_phase: assert property (@(posedge clock) disable iff (reset)
      (cur_vld_ff && !main_phase_ff) |-> cur_ff.flush_vld)
      else $error("flush phase on a job without a held surrogate");

   // byte index stays inside the code point length
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      (cur_vld_ff && main_phase_ff && cur_ff.main_kind == u16u8_pkg::MAIN_POINT)
         |-> ({1'b0, idx_ff} < cur_ff.main_len))
      else $error("byte index past end of sequence");

   // a marker is always the last result of its item
   a_marker_last: assert property (@(posedge clock) disable iff (reset)
      (advance && (pe_in || le_in)) |=> (rsp_valid && rsp_last && !rsp_byte_valid))
      else $error("marker result not flagged last");

endmodule
`default_nettype wire

// ===== hw/rtl/utf16_to_utf8_transcoder_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder_core
// Converts a stream of zero-terminated UTF-16 path strings to UTF-8 bytes.
// ----------------------------------------------------------------------------
// A code unit is taken every cycle while the four-entry job queue has room.
// Results leave at one per cycle while rsp_stall is low, paced by the back-end
// byte sequencer and its output register: a unit below 0x80 gives 1 result,
// below 0x800 2, any other BMP unit or lone surrogate 3, a surrogate pair 4
// (the high unit itself gives no result), a terminator 1 marker, and a held
// surrogate flushed ahead of the next unit adds 3. Each job passes through the
// job queue, the sequencer's current-job register and the result register.
// rsp_last marks the final result of each item.
// ----------------------------------------------------------------------------
module utf16_to_utf8_transcoder_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [15:0] req_code_unit,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [7:0]  rsp_out_byte,
   output      logic        rsp_byte_valid,
   output      logic        rsp_path_end,
   output      logic        rsp_list_end,
   output      logic        rsp_last
);

   logic               accept, push, pop, full, head_vld;
   u16u8_pkg::job_type push_job, head_job;

   // input handshake
   assign req_stall = full;
   assign accept    = req_valid && !full;

   u16u8_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .code_unit (req_code_unit),
      .push      (push),
      .job       (push_job)
   );

   u16u8_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .full     (full),
      .head_vld (head_vld),
      .head_job (head_job)
   );

   u16u8_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_vld       (head_vld),
      .head_job       (head_job),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_path_end   (rsp_path_end),
      .rsp_list_end   (rsp_list_end),
      .rsp_last       (rsp_last)
   );

endmodule
`default_nettype wire

// ===== dv/utf16_to_utf8_transcoder_core_tb.sv =====
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder_core_tb
// Drives zero-terminated UTF-16 path strings into the transcoder and checks
// every UTF-8 byte and marker against an in-bench encoder. A directed set
// covers the length classes, surrogate pairs, lone and flushed surrogates and
// the path and list markers. Random paths follow, with sender bursts and gaps
// and receiver stalls in changing patterns.
// ----------------------------------------------------------------------------
module utf16_to_utf8_transcoder_core_tb;

   localparam int          RANDOM_UNITS = 236;
   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int          DRAIN_CYCLES = 16;

   // one expected result item
   typedef struct packed {
      logic [7:0] octet;
      logic       carries_byte;
      logic       path_end;
      logic       list_end;
      logic       last;
   } utf8_result_type;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_RANDOM,
      STALL_PERIODIC,
      STALL_LONG
   } stall_mode_type;

   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic [15:0] req_code_unit  = 16'h0000;
   logic        rsp_stall      = 1'b0;
   logic        req_stall;
   logic        rsp_valid;
   logic [7:0]  rsp_out_byte;
   logic        rsp_byte_valid;
   logic        rsp_path_end;
   logic        rsp_list_end;
   logic        rsp_last;

   utf16_to_utf8_transcoder_core i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_code_unit  (req_code_unit),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_path_end   (rsp_path_end),
      .rsp_list_end   (rsp_list_end),
      .rsp_last       (rsp_last)
   );

   // encoder state and the bytes it still expects from the block
   class transcode_scoreboard;
      utf8_result_type expected_bytes[$];
      logic [9:0]      held_bits;
      logic            holding;
      logic            at_path_start;
      int unsigned     mismatches;
      int unsigned     units;
      int unsigned     checked;
      int unsigned     path_ends;
      int unsigned     list_ends;

      function new();
         held_bits     = 10'd0;
         holding       = 1'b0;
         at_path_start = 1'b1;
         mismatches    = 0;
         units         = 0;
         checked       = 0;
         path_ends     = 0;
         list_ends     = 0;
      endfunction

      function void push_result(logic [7:0] octet, logic carries, logic pe, logic le);
         utf8_result_type r;
         r.octet        = octet;
         r.carries_byte = carries;
         r.path_end     = pe;
         r.list_end     = le;
         r.last         = 1'b0;
         expected_bytes = {expected_bytes, r};
      endfunction

      // utf-8 bytes of one code point
      function void push_point(logic [20:0] cp);
         if (cp < 21'h80) begin
            push_result({1'b0, cp[6:0]}, 1'b1, 1'b0, 1'b0);
         end else if (cp < 21'h800) begin
            push_result(8'hC0 | {3'b0, cp[10:6]}, 1'b1, 1'b0, 1'b0);
            push_result(8'h80 | {2'b0, cp[5:0]}, 1'b1, 1'b0, 1'b0);
         end else if (cp < 21'h10000) begin
            push_result(8'hE0 | {4'b0, cp[15:12]}, 1'b1, 1'b0, 1'b0);
            push_result(8'h80 | {2'b0, cp[11:6]}, 1'b1, 1'b0, 1'b0);
            push_result(8'h80 | {2'b0, cp[5:0]}, 1'b1, 1'b0, 1'b0);
         end else begin
            push_result(8'hF0 | {5'b0, cp[20:18]}, 1'b1, 1'b0, 1'b0);
            push_result(8'h80 | {2'b0, cp[17:12]}, 1'b1, 1'b0, 1'b0);
            push_result(8'h80 | {2'b0, cp[11:6]}, 1'b1, 1'b0, 1'b0);
            push_result(8'h80 | {2'b0, cp[5:0]}, 1'b1, 1'b0, 1'b0);
         end
      endfunction

      // expected results of one accepted code unit
      function void note_unit(logic [15:0] u);
         int unsigned depth;
         logic [20:0] cp;
         depth = expected_bytes.size();
         units++;
         if (holding) begin
            if (u >= u16u8_pkg::SURR_LOW_MIN && u <= u16u8_pkg::SURR_LOW_MAX) begin
               // pair completes a supplementary code point
               cp = 21'h10000 + {1'b0, held_bits, u[9:0]};
               holding   = 1'b0;
               held_bits = 10'd0;
               push_point(cp);
               expected_bytes[expected_bytes.size() - 1].last = 1'b1;
               return;
            end
            // unpaired high surrogate leaves on its own
            push_point({5'b0, 6'b110110, held_bits});
            holding   = 1'b0;
            held_bits = 10'd0;
         end
         if (u == 16'h0000) begin
            if (at_path_start) begin
               push_result(8'h00, 1'b0, 1'b0, 1'b1);
            end else begin
               push_result(8'h00, 1'b0, 1'b1, 1'b0);
               at_path_start = 1'b1;
            end
         end else if (u >= u16u8_pkg::SURR_HIGH_MIN && u <= u16u8_pkg::SURR_HIGH_MAX) begin
            held_bits     = u[9:0];
            holding       = 1'b1;
            at_path_start = 1'b0;
         end else begin
            at_path_start = 1'b0;
            push_point({5'b0, u});
         end
         if (expected_bytes.size() > depth) begin
            expected_bytes[expected_bytes.size() - 1].last = 1'b1;
         end
      endfunction

      function void compare_field(string name, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatches++;
         end
      endfunction

      // compare one accepted result with the oldest expectation
      function void check_result(logic [7:0] octet, logic carries, logic pe, logic le,
                                 logic last);
         utf8_result_type want;
         checked++;
         if (expected_bytes.size() == 0) begin
            $error("unexpected result: out_byte %0h path_end %0b list_end %0b",
                   octet, pe, le);
            mismatches++;
            return;
         end
         want = expected_bytes.pop_front();
         compare_field("rsp_out_byte", want.octet, octet);
         compare_field("rsp_byte_valid", {7'b0, want.carries_byte}, {7'b0, carries});
         compare_field("rsp_path_end", {7'b0, want.path_end}, {7'b0, pe});
         compare_field("rsp_list_end", {7'b0, want.list_end}, {7'b0, le});
         compare_field("rsp_last", {7'b0, want.last}, {7'b0, last});
         if (want.path_end) path_ends++;
         if (want.list_end) list_ends++;
      endfunction

      function int unsigned pending();
         return expected_bytes.size();
      endfunction
   endclass

   transcode_scoreboard sb;

   int unsigned     cycle_count = 0;
   int unsigned     burst_left  = 0;
   int unsigned     mode_left   = 0;
   logic [7:0]      stall_phase = 8'd0;
   stall_mode_type  stall_mode  = STALL_NONE;

   // clock
   always #4 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // receiver stall, switching between patterns
   always @(negedge clock) begin
      if (mode_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         mode_left  = $urandom_range(20, 120);
      end
      mode_left--;
      stall_phase++;
      case (stall_mode)
         STALL_NONE:     rsp_stall = 1'b0;
         STALL_RANDOM:   rsp_stall = 1'($urandom_range(0, 1));
         STALL_PERIODIC: rsp_stall = (stall_phase % 3) != 0;
         default:        rsp_stall = stall_phase[3];
      endcase
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_result(rsp_out_byte, rsp_byte_valid, rsp_path_end, rsp_list_end,
                         rsp_last);
      end
   end

   // send one code unit; bursts with random gaps between them
   task automatic send_unit(input logic [15:0] u);
      int unsigned gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         burst_left = $urandom_range(1, 24);
         if (gap != 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      req_valid     = 1'b1;
      req_code_unit = u;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_unit(u);
      burst_left--;
      @(negedge clock);
   endtask

   // one random path string, mostly well formed, then its terminator and at times a second one
   task automatic send_random_path();
      int unsigned len;
      int unsigned pick;
      logic [15:0] u;
      len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 10);
      repeat (len) begin
         pick = $urandom_range(0, 99);
         if (pick < 28) begin
            send_unit(16'($urandom_range(16'h0001, 16'h007F)));
         end else if (pick < 44) begin
            send_unit(16'($urandom_range(16'h0080, 16'h07FF)));
         end else if (pick < 70) begin
            // three-byte unit, skipping the surrogate range
            u = 16'($urandom_range(16'h0800, 16'hF7FF));
            if (u >= u16u8_pkg::SURR_HIGH_MIN) u = u + 16'h0800;
            send_unit(u);
         end else if (pick < 84) begin
            send_unit(16'($urandom_range(u16u8_pkg::SURR_HIGH_MIN,
                                         u16u8_pkg::SURR_HIGH_MAX)));
            send_unit(16'($urandom_range(u16u8_pkg::SURR_LOW_MIN,
                                         u16u8_pkg::SURR_LOW_MAX)));
         end else if (pick < 90) begin
            send_unit(16'($urandom_range(u16u8_pkg::SURR_HIGH_MIN,
                                         u16u8_pkg::SURR_HIGH_MAX)));
         end else if (pick < 94) begin
            send_unit(16'($urandom_range(u16u8_pkg::SURR_LOW_MIN,
                                         u16u8_pkg::SURR_LOW_MAX)));
         end else begin
            send_unit(16'($urandom()));
         end
      end
      send_unit(16'h0000);
      if ($urandom_range(0, 5) == 0) send_unit(16'h0000);
   endtask

   // directed units: list end at start, length-class edges, pairs at both
   // ends, high surrogates flushed by the next unit (three of them), a terminator
   // that flushes, lone low surrogates
   logic [15:0] directed_units[] = '{
      16'h0000, 16'h0000, 16'h0001, 16'h007F, 16'h0080, 16'h07FF,
      16'h0800, 16'hFFFF, 16'hD800, 16'hDC00, 16'hDBFF, 16'hDFFF,
      16'hD800, 16'h0041, 16'hDBFF, 16'hFFFF, 16'hDA00, 16'hD9FF,
      16'h0000, 16'h0000, 16'hDC00, 16'hDFFF, 16'hE000, 16'h0000
   };

   initial begin
      sb = new();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_units[i]) send_unit(directed_units[i]);
      while (sb.units < directed_units.size() + RANDOM_UNITS) send_random_path();
      req_valid = 1'b0;

      // drain, then watch for stray results
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d code units sent, %0d results checked (%0d path ends, %0d list ends)",
               sb.units, sb.checked, sb.path_ends, sb.list_ends);
      $display("covered all length classes, pairs, lone and flushed surrogates, stalls");
      if (sb.mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/u16u8_pkg.sv
hw/rtl/u16u8_front.sv
hw/rtl/u16u8_queue.sv
hw/rtl/u16u8_back.sv
hw/rtl/utf16_to_utf8_transcoder_core.sv
dv/utf16_to_utf8_transcoder_core_tb.sv
